@@ hw/rtl/moorer_reverb_macros.svh @@
// Assertion macros for the moorer_reverb block.
// Included by the checker; needs aclk and aresetn in scope for MR_ASSERT.
`ifndef MOORER_REVERB_MACROS_SVH
`define MOORER_REVERB_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MR_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset.
`define MR_ASSERT(lbl, prop, msg) \
    `MR_ASSERT_RST(lbl, aclk, aresetn, prop, msg)

`endif

@@ hw/rtl/mrev_pkg.sv @@
// Shared types, constants and gain tables for the moorer_reverb block.
// No dependencies.
package mrev_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WIDE_W      = SAMPLE_BITS + 4;
    localparam int LP_W        = SAMPLE_BITS + 8;
    localparam int SUM_W       = WIDE_W + 3;
    localparam int COMB_MAX    = 6;
    localparam int COMB_IDX_W  = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int MUL_A_W     = 25;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int UNITY       = 32768;
    localparam int AP_MS       = 6;
    localparam int WET_W       = 16;
    localparam int APG_W       = 15;

    localparam logic [WET_W-1:0] WET_RESET = 16'd32768;
    localparam logic [APG_W-1:0] APG_RESET = 15'd13107;

    localparam int unsigned COMB_MS [COMB_MAX] = '{50, 56, 61, 68, 72, 78};
    localparam logic [15:0] COMB_G [COMB_MAX] =
        '{16'd15073, 16'd15729, 16'd16384, 16'd17039, 16'd17367, 16'd18022};
    localparam logic [15:0] LP_G [COMB_MAX] =
        '{16'd4856, 16'd4584, 16'd4424, 16'd4312, 16'd4040, 16'd5685};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_last;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          block_last_out;
    } out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WET_MIX = 2'd0,
        CFG_AP_GAIN = 2'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_C_RD, ST_C_WR, ST_C_UPD,
        ST_A_RD, ST_A_WR, ST_A_MIX, ST_MIX2, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_CLEAR, OP_LOAD, OP_C_RD, OP_C_WR, OP_C_UPD,
        OP_A_RD, OP_A_WR, OP_A_MIX, OP_MIX2, OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic comb_last;
        logic out_busy;
    } status_t;

endpackage

@@ hw/rtl/mrev_ctrl.sv @@
// Sequencer for moorer_reverb: clearing pass, comb, allpass, mix and output steps.
// Depends on mrev_pkg.
module mrev_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrev_pkg::status_t sts,
    output mrev_pkg::cmd_t    cmd
);

    mrev_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrev_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = mrev_pkg::OP_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            mrev_pkg::ST_CLEAR: begin
                cmd.op = mrev_pkg::OP_CLEAR;
                if (sts.clr_done) state_next = mrev_pkg::ST_IDLE;
            end
            mrev_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = mrev_pkg::OP_LOAD;
                    state_next = mrev_pkg::ST_C_RD;
                end
            end
            mrev_pkg::ST_C_RD: begin
                cmd.op     = mrev_pkg::OP_C_RD;
                state_next = mrev_pkg::ST_C_WR;
            end
            mrev_pkg::ST_C_WR: begin
                cmd.op     = mrev_pkg::OP_C_WR;
                state_next = mrev_pkg::ST_C_UPD;
            end
            mrev_pkg::ST_C_UPD: begin
                cmd.op     = mrev_pkg::OP_C_UPD;
                state_next = sts.comb_last ? mrev_pkg::ST_A_RD : mrev_pkg::ST_C_RD;
            end
            mrev_pkg::ST_A_RD: begin
                cmd.op     = mrev_pkg::OP_A_RD;
                state_next = mrev_pkg::ST_A_WR;
            end
            mrev_pkg::ST_A_WR: begin
                cmd.op     = mrev_pkg::OP_A_WR;
                state_next = mrev_pkg::ST_A_MIX;
            end
            mrev_pkg::ST_A_MIX: begin
                cmd.op     = mrev_pkg::OP_A_MIX;
                state_next = mrev_pkg::ST_MIX2;
            end
            mrev_pkg::ST_MIX2: begin
                cmd.op     = mrev_pkg::OP_MIX2;
                state_next = mrev_pkg::ST_OUT;
            end
            mrev_pkg::ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.op     = mrev_pkg::OP_OUT;
                    state_next = mrev_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrev_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/mrev_dp.sv @@
// Datapath for moorer_reverb: delay memories, lowpass states, shared multiplier,
// config registers and output register. Depends on mrev_pkg.
module mrev_dp #(
    parameter int SAMPLE_RATE_HZ = 48000,
    parameter int NUM_COMBS      = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mrev_pkg::cmd_t                     cmd,
    output mrev_pkg::status_t                  sts,
    input  mrev_pkg::in_t                      s_data,
    output mrev_pkg::out_t                     m_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               cfg_valid,
    input  logic [mrev_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrev_pkg::WET_W-1:0]         cfg_data
);

    localparam int unsigned LEN [mrev_pkg::COMB_MAX] = '{
        mrev_pkg::COMB_MS[0] * SAMPLE_RATE_HZ / 1000,
        mrev_pkg::COMB_MS[1] * SAMPLE_RATE_HZ / 1000,
        mrev_pkg::COMB_MS[2] * SAMPLE_RATE_HZ / 1000,
        mrev_pkg::COMB_MS[3] * SAMPLE_RATE_HZ / 1000,
        mrev_pkg::COMB_MS[4] * SAMPLE_RATE_HZ / 1000,
        mrev_pkg::COMB_MS[5] * SAMPLE_RATE_HZ / 1000
    };
    localparam int unsigned BASE [mrev_pkg::COMB_MAX] = '{
        0,
        LEN[0],
        LEN[0] + LEN[1],
        LEN[0] + LEN[1] + LEN[2],
        LEN[0] + LEN[1] + LEN[2] + LEN[3],
        LEN[0] + LEN[1] + LEN[2] + LEN[3] + LEN[4]
    };
    localparam int unsigned COMB_TOTAL = BASE[NUM_COMBS-1] + LEN[NUM_COMBS-1];
    localparam int unsigned AP_LEN     = mrev_pkg::AP_MS * SAMPLE_RATE_HZ / 1000;
    localparam int CM_AW = $clog2(COMB_TOTAL);
    localparam int AP_AW = $clog2(AP_LEN);
    localparam int POS_W = $clog2(LEN[mrev_pkg::COMB_MAX-1]);
    localparam int XW    = mrev_pkg::PROD_W + 1;
    localparam int WW    = mrev_pkg::WIDE_W;

    function automatic logic signed [XW-1:0] rnd(input logic signed [XW-1:0] p);
        return (p + XW'(16384)) >>> 15;
    endfunction

    function automatic logic signed [XW-1:0] sat(input logic signed [XW-1:0] v,
                                                 input int bits);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = (XW'(1) <<< (bits - 1)) - XW'(1);
        lo = -hi - XW'(1);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    logic signed [WW-1:0] cmem [COMB_TOTAL];
    logic signed [WW-1:0] amem [AP_LEN];

    mrev_pkg::in_t                         in_reg;
    logic [mrev_pkg::COMB_IDX_W-1:0]       j_reg;
    logic signed [mrev_pkg::LP_W-1:0]      lp_reg  [mrev_pkg::COMB_MAX];
    logic [POS_W-1:0]                      pos_reg [mrev_pkg::COMB_MAX];
    logic signed [mrev_pkg::SUM_W-1:0]     sum_reg;
    logic signed [mrev_pkg::PROD_W-1:0]    prod_reg;
    logic signed [mrev_pkg::PROD_W-1:0]    acc_reg;
    logic signed [WW-1:0]                  crd_reg;
    logic signed [WW-1:0]                  ard_reg;
    logic signed [WW-1:0]                  fb_reg;
    logic [CM_AW-1:0]                      caddr_reg;
    logic [AP_AW-1:0]                      ap_pos_reg;
    logic [CM_AW-1:0]                      clr_cnt_reg;
    logic [mrev_pkg::WET_W-1:0]            wet_reg;
    logic [mrev_pkg::APG_W-1:0]            apg_reg;
    mrev_pkg::out_t                        m_data_reg;
    logic                                  m_valid_reg;

    logic [16:0]                           wet_eff;
    logic signed [XW-1:0]                  s_wide;
    logic signed [WW-1:0]                  s_w;
    logic [CM_AW-1:0]                      caddr_w;
    logic signed [XW-1:0]                  prod_rnd;
    logic signed [XW-1:0]                  comb_wr;
    logic signed [XW-1:0]                  lp_new;
    logic signed [XW-1:0]                  ap_wr;
    logic signed [XW-1:0]                  y_wide;
    logic signed [XW-1:0]                  out_wide;
    logic signed [mrev_pkg::MUL_A_W-1:0]   mul_a;
    logic signed [mrev_pkg::MUL_B_W-1:0]   mul_b;
    logic [POS_W:0]                        pos_inc;
    logic                                  cm_we;
    logic [CM_AW-1:0]                      cm_waddr;
    logic signed [WW-1:0]                  cm_wdata;
    logic                                  am_we;
    logic [AP_AW-1:0]                      am_waddr;
    logic signed [WW-1:0]                  am_wdata;

    always_comb begin
        wet_eff  = (wet_reg > 16'd32768) ? 17'd32768 : {1'b0, wet_reg};
        s_wide   = sat(XW'(sum_reg), WW);
        s_w      = s_wide[WW-1:0];
        caddr_w  = CM_AW'(BASE[j_reg] + 32'(pos_reg[j_reg]));
        prod_rnd = rnd(XW'(prod_reg));
        comb_wr  = sat(XW'(in_reg.sample_in) + prod_rnd, WW);
        lp_new   = sat(XW'(crd_reg) + prod_rnd, mrev_pkg::LP_W);
        ap_wr    = sat(XW'(s_w) + prod_rnd, WW);
        y_wide   = XW'(ard_reg) + prod_rnd;
        out_wide = sat(rnd(XW'(acc_reg) + XW'(prod_reg)), mrev_pkg::SAMPLE_BITS);
        pos_inc  = {1'b0, pos_reg[j_reg]} + (POS_W+1)'(1);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            mrev_pkg::OP_C_RD: begin
                mul_a = mrev_pkg::MUL_A_W'(lp_reg[j_reg]);
                mul_b = $signed({2'b00, mrev_pkg::COMB_G[j_reg]});
            end
            mrev_pkg::OP_C_WR: begin
                mul_a = mrev_pkg::MUL_A_W'(lp_reg[j_reg]);
                mul_b = $signed({2'b00, mrev_pkg::LP_G[j_reg]});
            end
            mrev_pkg::OP_A_RD: begin
                mul_a = mrev_pkg::MUL_A_W'(fb_reg);
                mul_b = $signed({3'b000, apg_reg});
            end
            mrev_pkg::OP_A_WR: begin
                mul_a = -mrev_pkg::MUL_A_W'(s_w);
                mul_b = $signed({3'b000, apg_reg});
            end
            mrev_pkg::OP_A_MIX: begin
                mul_a = $signed(y_wide[mrev_pkg::MUL_A_W-1:0]);
                mul_b = $signed({1'b0, wet_eff});
            end
            mrev_pkg::OP_MIX2: begin
                mul_a = mrev_pkg::MUL_A_W'(in_reg.sample_in);
                mul_b = $signed({1'b0, 17'(mrev_pkg::UNITY) - wet_eff});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // memory write ports: clearing pass or normal update
    always_comb begin
        cm_we    = (cmd.op == mrev_pkg::OP_CLEAR) || (cmd.op == mrev_pkg::OP_C_WR);
        cm_waddr = (cmd.op == mrev_pkg::OP_CLEAR) ? clr_cnt_reg : caddr_reg;
        cm_wdata = (cmd.op == mrev_pkg::OP_CLEAR) ? '0 : comb_wr[WW-1:0];
        am_we    = ((cmd.op == mrev_pkg::OP_CLEAR) && (32'(clr_cnt_reg) < AP_LEN))
                   || (cmd.op == mrev_pkg::OP_A_WR);
        am_waddr = (cmd.op == mrev_pkg::OP_CLEAR) ? clr_cnt_reg[AP_AW-1:0] : ap_pos_reg;
        am_wdata = (cmd.op == mrev_pkg::OP_CLEAR) ? '0 : ap_wr[WW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cm_we) cmem[cm_waddr] <= cm_wdata;
        if (cmd.op == mrev_pkg::OP_C_RD) crd_reg <= cmem[caddr_w];
    end

    always_ff @(posedge aclk) begin
        if (am_we) amem[am_waddr] <= am_wdata;
        if (cmd.op == mrev_pkg::OP_A_RD) ard_reg <= amem[ap_pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg       <= '0;
            sum_reg     <= '0;
            fb_reg      <= '0;
            ap_pos_reg  <= '0;
            clr_cnt_reg <= '0;
            wet_reg     <= mrev_pkg::WET_RESET;
            apg_reg     <= mrev_pkg::APG_RESET;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < mrev_pkg::COMB_MAX; k++) begin
                lp_reg[k]  <= '0;
                pos_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (mrev_pkg::cfg_idx_t'(cfg_index))
                    mrev_pkg::CFG_WET_MIX: wet_reg <= cfg_data;
                    mrev_pkg::CFG_AP_GAIN: apg_reg <= cfg_data[mrev_pkg::APG_W-1:0];
                    default: ;
                endcase
            end
            unique case (cmd.op)
                mrev_pkg::OP_CLEAR: clr_cnt_reg <= clr_cnt_reg + CM_AW'(1);
                mrev_pkg::OP_LOAD: begin
                    sum_reg <= '0;
                    j_reg   <= '0;
                end
                mrev_pkg::OP_C_UPD: begin
                    lp_reg[j_reg]  <= lp_new[mrev_pkg::LP_W-1:0];
                    sum_reg        <= sum_reg + mrev_pkg::SUM_W'(crd_reg);
                    pos_reg[j_reg] <= (32'(pos_inc) >= LEN[j_reg]) ? '0
                                                                   : pos_inc[POS_W-1:0];
                    j_reg          <= sts.comb_last ? j_reg
                                                    : j_reg + mrev_pkg::COMB_IDX_W'(1);
                end
                mrev_pkg::OP_A_WR: begin
                    ap_pos_reg <= (32'(ap_pos_reg) + 1 >= AP_LEN) ? '0
                                                                  : ap_pos_reg + AP_AW'(1);
                end
                mrev_pkg::OP_A_MIX: fb_reg <= ard_reg;
                default: ;
            endcase
            if (cmd.op == mrev_pkg::OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == mrev_pkg::OP_LOAD) in_reg <= s_data;
        if (cmd.op == mrev_pkg::OP_C_RD) caddr_reg <= caddr_w;
        if (cmd.op == mrev_pkg::OP_MIX2) acc_reg <= prod_reg;
        // held while idle or waiting on the output register
        if (cmd.op != mrev_pkg::OP_NOP) prod_reg <= mul_a * mul_b;
        if (cmd.op == mrev_pkg::OP_OUT) begin
            m_data_reg.sample_out     <= out_wide[mrev_pkg::SAMPLE_BITS-1:0];
            m_data_reg.block_last_out <= in_reg.block_last;
        end
    end

    assign sts.clr_done  = (clr_cnt_reg == CM_AW'(COMB_TOTAL - 1));
    assign sts.comb_last = (j_reg == mrev_pkg::COMB_IDX_W'(NUM_COMBS - 1));
    assign sts.out_busy  = m_valid_reg && !m_ready;
    assign m_data        = m_data_reg;
    assign m_valid       = m_valid_reg;

endmodule

@@ hw/rtl/moorer_reverb.sv @@
// Top level of the moorer_reverb block: sequencer plus datapath.
// Depends on mrev_pkg, mrev_ctrl, mrev_dp.
//
//   channel   direction  ports                              word
//   s_        in         s_valid s_ready s_data             mrev_pkg::in_t
//   m_        out        m_valid m_ready m_data             mrev_pkg::out_t
//   cfg_      in         cfg_valid cfg_ready cfg_index/data register write
//
// Each sample is worked through in turn on the single shared multiplier: one step
// to take the word, three steps per comb, three for the allpass, two for the mix.
// After reset a pass over all COMB_TOTAL comb addresses (18480 at 48 kHz, six combs)
// zeroes both delay memories; s_ready stays low meanwhile, config writes are taken.
// A waiting result is held in the output register while the next word is accepted.
module moorer_reverb #(
    parameter int SAMPLE_RATE_HZ = 48000,
    parameter int NUM_COMBS      = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mrev_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mrev_pkg::out_t                     m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mrev_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrev_pkg::WET_W-1:0]         cfg_data
);

    mrev_pkg::cmd_t    cmd;
    mrev_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    mrev_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mrev_dp #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
        .NUM_COMBS      (NUM_COMBS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ hw/rtl/mrev_chk.sv @@
// Port-level checker for moorer_reverb, bound to the top level.
// Depends on mrev_pkg and moorer_reverb_macros.svh.
`include "moorer_reverb_macros.svh"

module mrev_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input mrev_pkg::in_t                      s_data,
    input logic                               m_valid,
    input logic                               m_ready,
    input mrev_pkg::out_t                     m_data,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [mrev_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [mrev_pkg::WET_W-1:0]         cfg_data
);

    `MR_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "m_data not held")
    `MR_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "back-to-back accept")
    `MR_ASSERT(a_no_early_result, $rose(m_valid) |-> !$past(s_valid && s_ready), "early result")

endmodule

bind moorer_reverb mrev_chk u_mrev_chk (.*);

@@ test/tb.sv @@
// Self-checking testbench for moorer_reverb: directed table, then random phases.
// Depends on mrev_pkg and the moorer_reverb RTL; holds its own reverb predictor.
`timescale 1ns / 100ps

module tb;

    localparam int AP_DEPTH   = 288;
    localparam int COMB_DEPTH = 18480;
    localparam int IDLE_LIMIT = 60000;
    localparam int SETTLE     = 40;
    localparam int HOLD_LONG  = 400;
    localparam int PHASE_LEN  = 420;
    localparam logic [mrev_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [mrev_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        bit                                do_cfg;
        logic [mrev_pkg::CFG_IDX_W-1:0]    idx;
        logic [mrev_pkg::WET_W-1:0]        wdata;
        logic signed [15:0]                smp;
        bit                                last;
        bit                                typed;
        logic signed [15:0]                want;
    } row_t;

    logic           aclk = 0;
    logic           aresetn = 0;
    logic           s_valid = 0;
    logic           s_ready;
    mrev_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 0;
    mrev_pkg::out_t m_data;
    logic           cfg_valid = 0;
    logic           cfg_ready;
    logic [mrev_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mrev_pkg::WET_W-1:0]     cfg_data = '0;

    // predictor state
    longint comb_mem [COMB_DEPTH];
    int     comb_len [mrev_pkg::COMB_MAX];
    int     comb_base [mrev_pkg::COMB_MAX];
    int     comb_pos [mrev_pkg::COMB_MAX];
    longint lp_state [mrev_pkg::COMB_MAX];
    longint ap_mem [AP_DEPTH];
    int     ap_pos;
    longint ap_fb;
    longint wet_reg;
    longint apg_reg;

    mrev_pkg::out_t want_q [$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_got = 0;
    int     n_cfg = 0;
    bit     calm = 0;
    bit     press_req = 0;
    bit     press_done = 0;
    int     hold_cnt = 0;
    int     idle_cnt = 0;
    row_t   rows [24];

    moorer_reverb u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    function automatic longint sat(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint rq15(longint p);
        return (p + 16384) >>> 15;
    endfunction

    function automatic void reverb_reset();
        int b;
        b = 0;
        foreach (comb_mem[i]) comb_mem[i] = 0;
        foreach (ap_mem[i]) ap_mem[i] = 0;
        for (int j = 0; j < mrev_pkg::COMB_MAX; j++) begin
            comb_len[j] = mrev_pkg::COMB_MS[j] * 48;
            comb_base[j] = b;
            b += comb_len[j];
            comb_pos[j] = 0;
            lp_state[j] = 0;
        end
        ap_pos = 0;
        ap_fb = 0;
        wet_reg = mrev_pkg::WET_RESET;
        apg_reg = mrev_pkg::APG_RESET;
    endfunction

    function automatic mrev_pkg::out_t reverb_step(mrev_pkg::in_t w);
        longint x, sum, s, d, ao, y, wet;
        mrev_pkg::out_t r;
        x = longint'(w.sample_in);
        sum = 0;
        for (int j = 0; j < mrev_pkg::COMB_MAX; j++) begin
            d = comb_mem[comb_base[j] + comb_pos[j]];
            comb_mem[comb_base[j] + comb_pos[j]] =
                sat(x + rq15(longint'(mrev_pkg::COMB_G[j]) * lp_state[j]), mrev_pkg::WIDE_W);
            comb_pos[j] = (comb_pos[j] + 1 >= comb_len[j]) ? 0 : comb_pos[j] + 1;
            lp_state[j] = sat(d + rq15(lp_state[j] * longint'(mrev_pkg::LP_G[j])),
                              mrev_pkg::LP_W);
            sum += d;
        end
        s = sat(sum, mrev_pkg::WIDE_W);
        ao = ap_mem[ap_pos];
        ap_mem[ap_pos] = sat(s + rq15(ap_fb * apg_reg), mrev_pkg::WIDE_W);
        ap_pos = (ap_pos + 1 >= AP_DEPTH) ? 0 : ap_pos + 1;
        ap_fb = ao;
        y = ao + rq15(-(apg_reg * s));
        wet = (wet_reg > mrev_pkg::UNITY) ? mrev_pkg::UNITY : wet_reg;
        r.sample_out = 16'(sat(rq15(y * wet + x * (mrev_pkg::UNITY - wet)),
                               mrev_pkg::SAMPLE_BITS));
        r.block_last_out = w.block_last;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    task automatic send_word(mrev_pkg::in_t w, bit typed, logic signed [15:0] want);
        int gap;
        mrev_pkg::out_t exp_r;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        exp_r = reverb_step(w);
        if (typed) exp_r.sample_out = want;
        want_q.push_back(exp_r);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (want_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [mrev_pkg::CFG_IDX_W-1:0] idx,
                             logic [mrev_pkg::WET_W-1:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == mrev_pkg::CFG_WET_MIX) wet_reg = v;
        else if (idx == mrev_pkg::CFG_AP_GAIN) apg_reg = v & 16'h7FFF;
        n_cfg++;
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic mrev_pkg::in_t rand_word(int mode);
        mrev_pkg::in_t w;
        case (mode)
            0: w.sample_in = 16'($urandom);
            1: w.sample_in = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
            default: w.sample_in = 16'($signed($urandom_range(0, 512)) - 256);
        endcase
        w.block_last = $urandom_range(0, 7) == 0;
        return w;
    endfunction

    // result side: random back-pressure and the scoreboard
    always @(posedge aclk) begin
        mrev_pkg::out_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            n_got++;
            if (want_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word sample=%0d last=%0b", $time,
                         got.sample_out, got.block_last_out);
            end else begin
                exp_r = want_q.pop_front();
                if (got.sample_out !== exp_r.sample_out) begin
                    errors++;
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             exp_r.sample_out, got.sample_out);
                end
                if (got.block_last_out !== exp_r.block_last_out) begin
                    errors++;
                    $display("%0t: block_last_out expected %0b actual %0b", $time,
                             exp_r.block_last_out, got.block_last_out);
                end
            end
        end
        if (press_req && !press_done) begin
            press_done <= 1;
            hold_cnt <= HOLD_LONG;
            m_ready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 0;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            m_ready <= 1;
        end else begin
            m_ready <= 0;
            hold_cnt <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 100)
                                                     : $urandom_range(0, 3);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > IDLE_LIMIT) begin
            $display("%0t: timeout, %0d words outstanding", $time, want_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        mrev_pkg::in_t w;
        int mode;
        logic [mrev_pkg::WET_W-1:0] wv;
        logic [mrev_pkg::WET_W-1:0] gv;
        reverb_reset();
        rows[0]  = '{1, CFG_SPARE_LO, 16'h0000, 16'sh7FFF, 0, 1, 16'sh0000};
        rows[1]  = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh8000, 1, 1, 16'sh0000};
        rows[2]  = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh0000, 0, 1, 16'sh0000};
        rows[3]  = '{0, mrev_pkg::CFG_WET_MIX, 0, -16'sd1, 1, 1, 16'sh0000};
        rows[4]  = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh5555, 0, 1, 16'sh0000};
        rows[5]  = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'shAAAA, 1, 1, 16'sh0000};
        rows[6]  = '{1, mrev_pkg::CFG_WET_MIX, 16'd0, 16'sh7FFF, 0, 1, 16'sh7FFF};
        rows[7]  = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh8000, 1, 1, 16'sh8000};
        rows[8]  = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh0001, 0, 1, 16'sh0001};
        rows[9]  = '{0, mrev_pkg::CFG_WET_MIX, 0, -16'sd1, 0, 1, -16'sd1};
        rows[10] = '{1, CFG_SPARE_HI, 16'hFFFF, 16'sh5555, 1, 1, 16'sh5555};
        rows[11] = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'shAAAA, 0, 1, 16'shAAAA};
        rows[12] = '{1, mrev_pkg::CFG_WET_MIX, 16'hFFFF, 16'sh7FFF, 0, 1, 16'sh0000};
        rows[13] = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh8000, 1, 1, 16'sh0000};
        rows[14] = '{1, mrev_pkg::CFG_WET_MIX, 16'd32768, 16'sh1234, 0, 1, 16'sh0000};
        rows[15] = '{1, mrev_pkg::CFG_AP_GAIN, 16'd0, 16'sh7FFF, 1, 0, 0};
        rows[16] = '{1, mrev_pkg::CFG_WET_MIX, 16'd16384, 16'sh8000, 0, 0, 0};
        rows[17] = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh7FFF, 0, 0, 0};
        rows[18] = '{1, mrev_pkg::CFG_AP_GAIN, 16'd32767, -16'sd2, 1, 0, 0};
        rows[19] = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh4000, 0, 0, 0};
        rows[20] = '{1, mrev_pkg::CFG_WET_MIX, 16'd32769, 16'shC000, 0, 0, 0};
        rows[21] = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh0100, 1, 0, 0};
        rows[22] = '{1, mrev_pkg::CFG_AP_GAIN, 16'd13107, 16'sh7FFF, 0, 0, 0};
        rows[23] = '{0, mrev_pkg::CFG_WET_MIX, 0, 16'sh8000, 1, 0, 0};
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        foreach (rows[i]) begin
            if (rows[i].do_cfg) begin
                drain();
                write_reg(rows[i].idx, rows[i].wdata);
            end
            w.sample_in = rows[i].smp;
            w.block_last = rows[i].last;
            send_word(w, rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin wv = 16'd32768; gv = 16'd32767; end
                1: begin wv = 16'd0; gv = 16'd0; end
                2: begin wv = 16'($urandom_range(32769, 65535));
                         gv = 16'(mrev_pkg::APG_RESET); end
                default: begin wv = 16'($urandom_range(0, 32768));
                               gv = 16'($urandom_range(0, 32767)); end
            endcase
            write_reg(mrev_pkg::CFG_WET_MIX, wv);
            write_reg(mrev_pkg::CFG_AP_GAIN, gv);
            for (int k = 0; k < PHASE_LEN; k++) begin
                calm = (ph == 1) && (k >= 200) && (k < 400);
                if (ph == 2 && k == 100) press_req = 1;
                mode = $urandom_range(0, 9);
                mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
                if (mode == 1) begin
                    for (int b = $urandom_range(5, 40); b > 0; b--) begin
                        send_word(rand_word(1), 0, 0);
                        k++;
                    end
                end else begin
                    send_word(rand_word(mode), 0, 0);
                end
            end
            calm = 0;
        end
        drain();

        $display("Sent %0d samples, checked %0d results, %0d register writes,", n_sent,
                 n_got, n_cfg);
        $display("covering full/zero/overrange wet mix and allpass gain extremes.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
